// ----- hdl/bvg_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the battery voltage gauge
// used by bvg_ctrl, bvg_dpath and battery_voltage_gauge_core
package bvg_pkg;

  // field widths
  localparam int MV_W      = 14;
  localparam int CODE_W    = 12;
  localparam int REF_W     = 11;
  localparam int PCT_W     = 7;
  localparam int NUM_W     = 23;   // 4095 * reference fits in 23 bits
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;  // adc_code, charge_pin_low, zero fill
  localparam int OUT_DATA_W = 24;  // battery_millivolts, charge_percent, charging, zero fill

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_MV     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_DETECT_MV = 2'd1;

  // reset values
  localparam logic [REF_W-1:0] REFERENCE_MV_RST     = 11'd1200;
  localparam logic [MV_W-1:0]  CHARGE_DETECT_MV_RST = 14'd4180;
  localparam logic [MV_W-1:0]  FILTERED_MV_RST      = 14'd3300;

  // acceptance window for the conversion code (exclusive bounds)
  localparam logic [CODE_W-1:0] CODE_MIN_EXCL = 12'd500;
  localparam logic [CODE_W-1:0] CODE_FULL     = 12'd4095;
  localparam logic [MV_W-1:0]   MV_MAX        = 14'd16383;

  // last step of the bit-serial divider
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture input item and start
    logic step;   // one divider iteration
    logic fold;   // update filtered voltage
    logic emit;   // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_window;  // offered item gives a new voltage
    logic div_last;   // divider on its final iteration
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ----- hdl/battery_voltage_gauge_core.sv -----
`timescale 1ns / 1ps
// top level of the battery voltage gauge
// depends on bvg_pkg, bvg_ctrl and bvg_dpath

// Takes one reading of the internal bandgap reference per transaction and
// returns one result: the filtered supply voltage, a 0..100 state of charge
// from a piecewise Li-ion curve, and a charging flag. A good sample with a
// code strictly between 500 and 4095 runs 4095 * reference / code through a
// one-bit-per-cycle restoring divider; the fold state then filters its
// quotient into the voltage and the emit state loads the result. Any other
// sample goes straight to the emit state and leaves the filtered voltage
// as it was. The emit state waits while the output register holds a result
// that m_tready has not taken. One item is in work at a time. The output
// register lets a new item be taken while the previous result waits.
// Configuration writes are always taken and are meant for idle periods only.
module battery_voltage_gauge_core
  import bvg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] adc_code, [12] charge_pin_low, [15:13] zero
  input  logic                  s_tuser,   // [0] conversion_ok
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [13:0] battery_millivolts,
                                           // [20:14] charge_percent, [21] charging, [23:22] zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MV_W-1:0]       cfg_data
);

  cmd_t    cmd;
  status_t status;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // sequencer
  bvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and result register
  bvg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- hdl/bvg_ctrl.sv -----
`timescale 1ns / 1ps
// sequencing state machine of the battery voltage gauge
// depends on bvg_pkg for state and command types
module bvg_ctrl
  import bvg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.in_window ? ST_DIVIDE : ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/bvg_dpath.sv -----
`timescale 1ns / 1ps
// datapath: configuration registers, bit-serial divider, filter,
// charge curve and output register; depends on bvg_pkg
module bvg_dpath
  import bvg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MV_W-1:0]       cfg_data,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // charge curve segments, lowest first
  localparam int NSEG = 8;
  localparam logic [MV_W-1:0] SEG_LO [NSEG] = '{
    14'd3300, 14'd3450, 14'd3600, 14'd3700, 14'd3780, 14'd3850, 14'd3950, 14'd4050
  };
  localparam logic [PCT_W-1:0] SEG_BASE [NSEG] = '{
    7'd1, 7'd10, 7'd20, 7'd35, 7'd50, 7'd65, 7'd80, 7'd90
  };
  // den/span scaled by 2**20, rounded up so truncation stays exact
  localparam logic [17:0] SEG_RECIP [NSEG] = '{
    18'(((2**20) * 9)  / 150 + 1),
    18'(((2**20) * 10) / 150 + 1),
    18'(((2**20) * 15) / 100 + 1),
    18'(((2**20) * 15) / 80  + 1),
    18'(((2**20) * 15) / 70  + 1),
    18'(((2**20) * 15) / 100 + 1),
    18'(((2**20) * 10) / 100 + 1),
    18'(((2**20) * 10) / 100 + 1)
  };
  localparam logic [MV_W-1:0]  MV_FULL_CHARGE = 14'd4150;
  localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;

  logic [REF_W-1:0]  reference_mv;
  logic [MV_W-1:0]   charge_detect_mv;
  logic [MV_W-1:0]   filtered_mv;
  logic              pin_low;
  logic [CODE_W-1:0] divisor;
  logic [CODE_W-1:0] rem;
  logic [NUM_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;

  logic [CODE_W-1:0] in_code;
  logic [NUM_W-1:0]  ref_ext;
  logic [NUM_W-1:0]  numer;
  logic [CODE_W:0]   trial;
  logic [CODE_W:0]   trial_diff;
  logic              trial_ge;
  logic [MV_W-1:0]   inst_mv;
  logic [MV_W+2:0]   fold_sum;

  // input fields
  assign in_code = s_tdata[CODE_W-1:0];

  // a sample counts only if good and strictly inside the code window
  assign status.in_window = s_tuser && (in_code > CODE_MIN_EXCL) && (in_code < CODE_FULL);
  assign status.div_last  = (cnt == DIV_LAST);
  assign status.out_free  = !m_tvalid || m_tready;

  // 4095 * reference as (reference << 12) - reference
  assign ref_ext = NUM_W'(reference_mv);
  assign numer   = (ref_ext << CODE_W) - ref_ext;

  // restoring division step
  assign trial      = {rem, quo[NUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  // saturate the instantaneous voltage to 14 bits
  assign inst_mv = (|quo[NUM_W-1:MV_W]) ? MV_MAX : quo[MV_W-1:0];

  // seven eighths old plus one eighth new
  assign fold_sum = ((MV_W+3)'(filtered_mv) << 3) - (MV_W+3)'(filtered_mv)
                  + (MV_W+3)'(inst_mv);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv     <= REFERENCE_MV_RST;
      charge_detect_mv <= CHARGE_DETECT_MV_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REFERENCE_MV:     reference_mv     <= cfg_data[REF_W-1:0];
        REG_CHARGE_DETECT_MV: charge_detect_mv <= cfg_data;
        default: ;
      endcase
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pin_low <= s_tdata[CODE_W];
      divisor <= in_code;
      rem     <= '0;
      quo     <= numer;
      cnt     <= '0;
    end else if (cmd.step) begin
      rem <= trial_ge ? trial_diff[CODE_W-1:0] : trial[CODE_W-1:0];
      quo <= {quo[NUM_W-2:0], trial_ge};
      cnt <= cnt + 1'b1;
    end
  end

  // filtered voltage
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_mv <= FILTERED_MV_RST;
    end else if (cmd.fold) begin
      filtered_mv <= fold_sum[MV_W+2:3];
    end
  end

  // charge curve segment lookup
  logic [2:0]       seg;
  logic             seg_hit;
  logic [MV_W-1:0]  seg_off;
  logic [25:0]      seg_prod;
  logic [PCT_W-1:0] percent;

  always_comb begin
    seg     = '0;
    seg_hit = 1'b0;
    for (int i = 0; i < NSEG; i++) begin
      if (filtered_mv >= SEG_LO[i]) begin
        seg     = 3'(i);
        seg_hit = 1'b1;
      end
    end
  end

  assign seg_off  = filtered_mv - SEG_LO[seg];
  assign seg_prod = 26'(seg_off[7:0]) * 26'(SEG_RECIP[seg]);

  always_comb begin
    if (filtered_mv >= MV_FULL_CHARGE) begin
      percent = PCT_FULL;
    end else if (!seg_hit) begin
      percent = '0;
    end else begin
      percent = SEG_BASE[seg] + PCT_W'(seg_prod[25:20]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00,
                  pin_low || (filtered_mv >= charge_detect_mv),
                  percent,
                  filtered_mv};
    end
  end

endmodule
